@@ hdl/lowest_first_unit_allocator_defines.svh @@
// Assertion macros shared by the unit allocator modules.
// Included by the controller and the datapath; depends on nothing else.
`ifndef LOWEST_FIRST_UNIT_ALLOCATOR_DEFINES_SVH
`define LOWEST_FIRST_UNIT_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFUA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFUA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lfua_pkg.sv @@
// Shared types and constants of the lowest-first unit allocator.
// Used by lfua_dp, lfua_ctrl and the top level; depends on nothing.
package lfua_pkg;

    localparam int UNITS_DEF   = 1024;
    localparam int HANDLES_DEF = 255;

    // Widths of the request and result fields.
    localparam int REQ_W      = 2;
    localparam int SIZE_W     = 11;
    localparam int HID_W      = 8;
    localparam int RANK_W     = 10;
    localparam int ADDR_OUT_W = 10;
    localparam int AH_W       = 8;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic decide;
        logic scan;
        logic load_out;
    } lfua_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic clear_done;
        logic need_scan;
        logic scan_done;
        logic out_free;
    } lfua_stat_t;

endpackage

@@ hdl/lfua_dp.sv @@
// Datapath of the unit allocator: owner table, handle table, counters, result register.
// Depends on lfua_pkg and the assertion macros header.
`include "lowest_first_unit_allocator_defines.svh"

module lfua_dp #(
    parameter int UNITS   = lfua_pkg::UNITS_DEF,
    parameter int HANDLES = lfua_pkg::HANDLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lfua_pkg::lfua_cmd_t               cmd,
    output lfua_pkg::lfua_stat_t              stat,
    input  lfua_pkg::req_t                    in_req,
    input  logic [lfua_pkg::SIZE_W-1:0]       in_size,
    input  logic [lfua_pkg::HID_W-1:0]        in_handle,
    input  logic [lfua_pkg::RANK_W-1:0]       in_rank,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              out_failed,
    output logic [lfua_pkg::ADDR_OUT_W-1:0]   out_addr,
    output logic [lfua_pkg::AH_W-1:0]         out_assigned
);

    localparam int AW    = $clog2(UNITS);
    localparam int HW    = $clog2(HANDLES + 1);
    localparam int UW    = $clog2(UNITS + 1);
    localparam int CLR_N = (UNITS > HANDLES + 1) ? UNITS : HANDLES + 1;
    localparam int CW    = $clog2(CLR_N);

    // Storage.
    logic [HW-1:0] owner_mem  [UNITS];
    logic          hlive_mem  [HANDLES+1];
    logic [UW-1:0] hunits_mem [HANDLES+1];

    // Latched request.
    lfua_pkg::req_t             req_reg;
    logic [lfua_pkg::SIZE_W-1:0] size_reg;
    logic [lfua_pkg::HID_W-1:0]  h_reg;
    logic [lfua_pkg::RANK_W-1:0] rank_reg;
    logic                        hlive_rd_reg;
    logic [UW-1:0]               hunits_rd_reg;

    // Control state.
    logic [HW-1:0] issued_reg;
    logic [UW-1:0] free_units_reg;
    logic [CW-1:0] clr_ptr_reg;
    logic [AW-1:0] scan_ptr_reg;
    logic          data_vld_reg;
    logic [UW-1:0] left_reg;
    logic          out_vld_reg;

    // Scan payload and result.
    logic [AW-1:0] data_addr_reg;
    logic [HW-1:0] rdata_reg;
    logic [HW-1:0] scan_h_reg;
    logic          res_failed_reg;
    logic [AW-1:0] res_addr_reg;
    logic [HW-1:0] res_assigned_reg;
    logic                              out_failed_reg;
    logic [lfua_pkg::ADDR_OUT_W-1:0]   out_addr_reg;
    logic [lfua_pkg::AH_W-1:0]         out_assigned_reg;

    // Decision made once the handle table entry has been read.
    logic          h_ok;
    logic          issued_full;
    logic          fits;
    logic [HW-1:0] h_idx;
    logic [HW-1:0] new_h;
    logic          dec_failed;
    logic [HW-1:0] dec_assigned;
    logic          dec_need_scan;
    logic          dec_issue;
    logic          dec_hwr;
    logic [HW-1:0] dec_hwr_idx;
    logic          dec_hwr_live;
    logic [UW-1:0] dec_hwr_units;
    logic [UW-1:0] dec_free_next;
    logic [UW-1:0] dec_left;
    logic [HW-1:0] dec_scan_h;

    // Scan step.
    logic          hit_free;
    logic          hit_own;
    logic          at_last;
    logic          scan_act;
    logic          scan_wr;
    logic [HW-1:0] scan_wr_val;
    logic          scan_dec;
    logic          scan_found;
    logic          scan_end;

    // Memory write ports.
    logic          clr_in_units;
    logic          clr_in_handles;
    logic          own_we;
    logic [AW-1:0] own_wa;
    logic [HW-1:0] own_wd;
    logic          hm_we;
    logic [HW-1:0] hm_wa;
    logic          hm_wlive;
    logic [UW-1:0] hm_wunits;

    assign h_idx       = HW'(h_reg);
    assign new_h       = issued_reg + HW'(1);
    assign issued_full = (32'(issued_reg) == HANDLES);
    assign fits        = (32'(size_reg) <= 32'(free_units_reg));
    assign h_ok        = (h_reg != '0) && (32'(h_reg) <= 32'(issued_reg)) && hlive_rd_reg;

    always_comb
    begin
        dec_failed    = 1'b1;
        dec_assigned  = '0;
        dec_need_scan = 1'b0;
        dec_issue     = 1'b0;
        dec_hwr       = 1'b0;
        dec_hwr_idx   = h_idx;
        dec_hwr_live  = 1'b0;
        dec_hwr_units = '0;
        dec_free_next = free_units_reg;
        dec_left      = '0;
        dec_scan_h    = h_idx;
        case (req_reg)
            lfua_pkg::REQ_ALLOC:
            begin
                // The handle number is consumed even when the pool is too small.
                if (!issued_full)
                begin
                    dec_issue    = 1'b1;
                    dec_assigned = new_h;
                    dec_scan_h   = new_h;
                    if (fits)
                    begin
                        dec_failed    = 1'b0;
                        dec_hwr       = 1'b1;
                        dec_hwr_idx   = new_h;
                        dec_hwr_live  = 1'b1;
                        dec_hwr_units = UW'(size_reg);
                        dec_free_next = free_units_reg - UW'(size_reg);
                        dec_left      = UW'(size_reg);
                        dec_need_scan = (size_reg != '0);
                    end
                end
            end
            lfua_pkg::REQ_FREE:
            begin
                if (h_ok)
                begin
                    dec_failed    = 1'b0;
                    dec_hwr       = 1'b1;
                    dec_free_next = free_units_reg + hunits_rd_reg;
                    dec_need_scan = 1'b1;
                end
            end
            lfua_pkg::REQ_QUERY:
            begin
                if (h_ok && (32'(rank_reg) < 32'(hunits_rd_reg)))
                begin
                    dec_left      = UW'(rank_reg);
                    dec_need_scan = 1'b1;
                end
            end
            default:
            begin
                dec_failed = 1'b1;
            end
        endcase
    end

    assign hit_free = (rdata_reg == '0);
    assign hit_own  = (rdata_reg == scan_h_reg);
    assign at_last  = (data_addr_reg == AW'(UNITS - 1));
    assign scan_act = cmd.scan && data_vld_reg;

    always_comb
    begin
        scan_wr     = 1'b0;
        scan_wr_val = '0;
        scan_dec    = 1'b0;
        scan_found  = 1'b0;
        scan_end    = 1'b0;
        case (req_reg)
            lfua_pkg::REQ_ALLOC:
            begin
                if (hit_free)
                begin
                    scan_wr     = 1'b1;
                    scan_wr_val = scan_h_reg;
                    scan_dec    = 1'b1;
                end
                scan_end = (hit_free && (left_reg == UW'(1))) || at_last;
            end
            lfua_pkg::REQ_FREE:
            begin
                scan_wr  = hit_own;
                scan_end = at_last;
            end
            lfua_pkg::REQ_QUERY:
            begin
                if (hit_own)
                begin
                    if (left_reg == '0)
                    begin
                        scan_found = 1'b1;
                    end
                    else
                    begin
                        scan_dec = 1'b1;
                    end
                end
                scan_end = scan_found || at_last;
            end
            default:
            begin
                scan_end = 1'b1;
            end
        endcase
    end

    assign clr_in_units   = (32'(clr_ptr_reg) < UNITS);
    assign clr_in_handles = (32'(clr_ptr_reg) <= HANDLES);

    always_comb
    begin
        if (cmd.clear)
        begin
            own_we = clr_in_units;
            own_wa = clr_ptr_reg[AW-1:0];
            own_wd = '0;
        end
        else
        begin
            own_we = scan_act && scan_wr;
            own_wa = data_addr_reg;
            own_wd = scan_wr_val;
        end
    end

    always_comb
    begin
        if (cmd.clear)
        begin
            hm_we     = clr_in_handles;
            hm_wa     = clr_ptr_reg[HW-1:0];
            hm_wlive  = 1'b0;
            hm_wunits = '0;
        end
        else
        begin
            hm_we     = cmd.decide && dec_hwr;
            hm_wa     = dec_hwr_idx;
            hm_wlive  = dec_hwr_live;
            hm_wunits = dec_hwr_units;
        end
    end

    assign stat.clear_done = (clr_ptr_reg == CW'(CLR_N - 1));
    assign stat.need_scan  = dec_need_scan;
    assign stat.scan_done  = data_vld_reg && scan_end;
    assign stat.out_free   = !out_vld_reg || out_ready;

    // Owner table: one write port, one registered read port that follows the scan pointer.
    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            owner_mem[own_wa] <= own_wd;
        end
        rdata_reg <= owner_mem[scan_ptr_reg];
    end

    // Handle table: read at the incoming handle when a word is accepted.
    always_ff @(posedge clk)
    begin
        if (hm_we)
        begin
            hlive_mem[hm_wa]  <= hm_wlive;
            hunits_mem[hm_wa] <= hm_wunits;
        end
        if (cmd.accept)
        begin
            hlive_rd_reg  <= hlive_mem[HW'(in_handle)];
            hunits_rd_reg <= hunits_mem[HW'(in_handle)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issued_reg     <= '0;
            free_units_reg <= UW'(UNITS);
            clr_ptr_reg    <= '0;
            scan_ptr_reg   <= '0;
            data_vld_reg   <= 1'b0;
            left_reg       <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear && !stat.clear_done)
            begin
                clr_ptr_reg <= clr_ptr_reg + CW'(1);
            end
            if (cmd.decide)
            begin
                if (dec_issue)
                begin
                    issued_reg <= new_h;
                end
                free_units_reg <= dec_free_next;
                left_reg       <= dec_left;
                scan_ptr_reg   <= '0;
                data_vld_reg   <= 1'b0;
            end
            else if (cmd.scan)
            begin
                data_vld_reg <= 1'b1;
                if (scan_ptr_reg != AW'(UNITS - 1))
                begin
                    scan_ptr_reg <= scan_ptr_reg + AW'(1);
                end
                if (scan_act && scan_dec)
                begin
                    left_reg <= left_reg - UW'(1);
                end
            end
            if (cmd.load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg  <= in_req;
            size_reg <= in_size;
            h_reg    <= in_handle;
            rank_reg <= in_rank;
        end
        if (cmd.scan)
        begin
            data_addr_reg <= scan_ptr_reg;
        end
        if (cmd.decide)
        begin
            res_failed_reg   <= dec_failed;
            res_addr_reg     <= '0;
            res_assigned_reg <= dec_assigned;
            scan_h_reg       <= dec_scan_h;
        end
        else if (scan_act && scan_found)
        begin
            res_failed_reg <= 1'b0;
            res_addr_reg   <= data_addr_reg;
        end
        if (cmd.load_out)
        begin
            out_failed_reg   <= res_failed_reg;
            out_addr_reg     <= lfua_pkg::ADDR_OUT_W'(res_addr_reg);
            out_assigned_reg <= lfua_pkg::AH_W'(res_assigned_reg);
        end
    end

    assign out_valid    = out_vld_reg;
    assign out_failed   = out_failed_reg;
    assign out_addr     = out_addr_reg;
    assign out_assigned = out_assigned_reg;

    `LFUA_ASSERT_NOW(a_free_bound, clk, rst_n, 1'b1, 32'(free_units_reg) <= UNITS, "free count above pool size")
    `LFUA_ASSERT_NOW(a_fail_addr, clk, rst_n, out_vld_reg && out_failed_reg, out_addr_reg == '0, "failed word carries an address")

endmodule

@@ hdl/lfua_ctrl.sv @@
// Controller of the unit allocator: sequences clearing, table lookup, scan and result.
// Depends on lfua_pkg and the assertion macros header.
`include "lowest_first_unit_allocator_defines.svh"

module lfua_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output lfua_pkg::lfua_cmd_t  cmd,
    input  lfua_pkg::lfua_stat_t stat
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = stat.need_scan ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.clear    = (state_reg == ST_CLEAR);
    assign cmd.accept   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.decide   = (state_reg == ST_LOOK);
    assign cmd.scan     = (state_reg == ST_SCAN);
    assign cmd.load_out = (state_reg == ST_DONE) && stat.out_free;

    `LFUA_ASSERT_NEXT(a_accept_look, clk, rst_n, cmd.accept, state_reg == ST_LOOK, "accepted word not looked up")
    `LFUA_ASSERT_NEXT(a_scan_end, clk, rst_n, cmd.scan && stat.scan_done, state_reg == ST_DONE, "scan did not end")

endmodule

@@ hdl/lowest_first_unit_allocator.sv @@
// Top level of the lowest-first unit allocator: stream ports, controller and datapath.
// Depends on lfua_pkg, lfua_ctrl and lfua_dp.
//
//  Channel  Direction  Handshake         Contents
//  s_*      in         s_tvalid/tready   request word: kind in tuser, operands in tdata
//  m_*      out        m_tvalid/tready   result word: failed flag in tuser, address/handle
//
// A request passes through lookup, an optional scan and a result state: an allocate scans the owner table one
// unit per cycle until its units are bound, a free scans all UNITS entries, a query scans
// up to the requested unit; this scan rate is set by the single read port of the owner
// table. After reset a clearing pass zeroes both tables before s_tready rises. A finished
// result waits in the output register while the next request is accepted; only a stalled
// result blocks the next one.

module lowest_first_unit_allocator #(
    parameter int UNITS   = lfua_pkg::UNITS_DEF,
    parameter int HANDLES = lfua_pkg::HANDLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // alloc_size[10:0], handle_id[18:11], unit_offset[28:19], zero fill
    input  logic [lfua_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type[1:0]
    input  logic [lfua_pkg::REQ_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // unit_address[9:0], assigned_handle[17:10], zero fill
    output logic [lfua_pkg::M_TDATA_W-1:0]    m_tdata,
    // failed
    output logic                              m_tuser
);

    localparam int HID_LO  = lfua_pkg::SIZE_W;
    localparam int RANK_LO = lfua_pkg::SIZE_W + lfua_pkg::HID_W;
    localparam int M_USED  = lfua_pkg::ADDR_OUT_W + lfua_pkg::AH_W;

    lfua_pkg::lfua_cmd_t  cmd;
    lfua_pkg::lfua_stat_t stat;

    logic [lfua_pkg::ADDR_OUT_W-1:0] out_addr;
    logic [lfua_pkg::AH_W-1:0]       out_assigned;

    lfua_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lfua_dp #(
        .UNITS   (UNITS),
        .HANDLES (HANDLES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_req       (lfua_pkg::req_t'(s_tuser)),
        .in_size      (s_tdata[lfua_pkg::SIZE_W-1:0]),
        .in_handle    (s_tdata[HID_LO +: lfua_pkg::HID_W]),
        .in_rank      (s_tdata[RANK_LO +: lfua_pkg::RANK_W]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_failed   (m_tuser),
        .out_addr     (out_addr),
        .out_assigned (out_assigned)
    );

    assign m_tdata = {{(lfua_pkg::M_TDATA_W - M_USED){1'b0}}, out_assigned, out_addr};

endmodule

@@ tb/allocator_check.sv @@
`timescale 1ns / 100ps
// Result checker for the lowest-first unit allocator. It watches both stream channels, keeps
// its own copy of the unit pool and compares each result word. Depends on lfua_pkg.
module allocator_check #(
    parameter int UNITS   = lfua_pkg::UNITS_DEF,
    parameter int HANDLES = lfua_pkg::HANDLES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // alloc_size[10:0], handle_id[18:11], unit_offset[28:19], zero fill
    input  logic [lfua_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [lfua_pkg::REQ_W-1:0]     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // unit_address[9:0], assigned_handle[17:10], zero fill
    input  logic [lfua_pkg::M_TDATA_W-1:0] m_tdata,
    // failed
    input  logic                           m_tuser,
    output int                             errors,
    output int                             outstanding
);
    import lfua_pkg::*;

    typedef struct packed {
        logic                  failed;
        logic [ADDR_OUT_W-1:0] unit_addr;
        logic [AH_W-1:0]       handle_no;
    } alloc_result_t;

    // Pool state: owning handle per unit (zero means free) and per-handle bookkeeping.
    logic [HID_W-1:0] unit_owner [UNITS];
    bit               handle_held [HANDLES+1];
    int unsigned      handle_size [HANDLES+1];
    int unsigned      last_handle;
    int unsigned      units_free;

    alloc_result_t    expected_results [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic bit handle_valid(input int unsigned h);
        return h != 0 && h <= last_handle && h <= HANDLES && handle_held[h];
    endfunction

    function automatic alloc_result_t serve_request(input logic [REQ_W-1:0] kind,
            input int unsigned size, input int unsigned hid, input int unsigned rank);
        alloc_result_t res;
        int unsigned   left;
        int            i;
        res = '0;
        res.failed = 1'b1;
        case (kind)
            REQ_ALLOC:
            begin
                // The handle number is spent even when the pool is too short.
                if (last_handle < HANDLES)
                begin
                    last_handle++;
                    res.handle_no = last_handle[AH_W-1:0];
                    if (size <= units_free)
                    begin
                        left = size;
                        for (i = 0; i < UNITS && left != 0; i++)
                        begin
                            if (unit_owner[i] == '0)
                            begin
                                unit_owner[i] = last_handle[HID_W-1:0];
                                left--;
                            end
                        end
                        units_free -= size;
                        handle_held[last_handle] = 1'b1;
                        handle_size[last_handle] = size;
                        res.failed = 1'b0;
                    end
                end
            end
            REQ_FREE:
            begin
                if (handle_valid(hid))
                begin
                    for (i = 0; i < UNITS; i++)
                    begin
                        if (unit_owner[i] == hid[HID_W-1:0])
                            unit_owner[i] = '0;
                    end
                    units_free += handle_size[hid];
                    handle_size[hid] = 0;
                    handle_held[hid] = 1'b0;
                    res.failed = 1'b0;
                end
            end
            REQ_QUERY:
            begin
                if (handle_valid(hid) && rank < handle_size[hid])
                begin
                    left = rank;
                    for (i = 0; i < UNITS; i++)
                    begin
                        if (unit_owner[i] == hid[HID_W-1:0])
                        begin
                            if (left == 0)
                            begin
                                res.unit_addr = i[ADDR_OUT_W-1:0];
                                res.failed = 1'b0;
                                break;
                            end
                            left--;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        alloc_result_t want;
        int            k;
        if (!rst_n)
        begin
            for (k = 0; k < UNITS; k++)
                unit_owner[k] = '0;
            for (k = 0; k <= HANDLES; k++)
            begin
                handle_held[k] = 1'b0;
                handle_size[k] = 0;
            end
            last_handle = 0;
            units_free = UNITS;
            expected_results.delete();
            errors = 0;
            outstanding <= 0;
        end
        else
        begin
            // A result word always belongs to an earlier request, so retire before adding.
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result word with nothing pending, failed flag",
                                    int'(m_tuser), 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.failed)
                        report_mismatch("failed", int'(m_tuser), int'(want.failed));
                    if (m_tdata[ADDR_OUT_W-1:0] !== want.unit_addr)
                        report_mismatch("unit_address", int'(m_tdata[ADDR_OUT_W-1:0]),
                                        int'(want.unit_addr));
                    if (m_tdata[ADDR_OUT_W +: AH_W] !== want.handle_no)
                        report_mismatch("assigned_handle", int'(m_tdata[ADDR_OUT_W +: AH_W]),
                                        int'(want.handle_no));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(serve_request(s_tuser,
                    32'(s_tdata[SIZE_W-1:0]),
                    32'(s_tdata[SIZE_W +: HID_W]),
                    32'(s_tdata[SIZE_W+HID_W +: RANK_W])));
            outstanding <= expected_results.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for lowest_first_unit_allocator: clock, reset, request stimulus, output
// stalls and the verdict. Depends on lfua_pkg, the allocator RTL and allocator_check.
module tb;
    import lfua_pkg::*;

    localparam int UNITS   = UNITS_DEF;
    localparam int HANDLES = HANDLES_DEF;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int PHASES           = 4;
    localparam int RANDOM_PER_PHASE = 145;
    localparam int DRAIN_CYCLES     = UNITS + 8;
    // Covers the clearing pass, a full-table scan and long output stalls many times over.
    localparam int IDLE_LIMIT       = 16 * (UNITS + 8);

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int errors;
    int outstanding;
    int send_idle_pct   = 0;
    int ready_stall_pct = 0;
    int phase_idle  [PHASES] = '{0, 57, 0, 10};
    int phase_stall [PHASES] = '{0, 0, 57, 10};

    // Handles the stimulus has spent so far and the size each one asked for.
    int          handles_used = 0;
    int unsigned asked_size [HANDLES+1];

    lowest_first_unit_allocator #(
        .UNITS   (UNITS),
        .HANDLES (HANDLES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    allocator_check #(
        .UNITS   (UNITS),
        .HANDLES (HANDLES)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [SIZE_W-1:0] size,
            input logic [HID_W-1:0] hid, input logic [RANK_W-1:0] rank);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-SIZE_W-HID_W-RANK_W){1'b0}}, rank, hid, size};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == REQ_ALLOC && handles_used < HANDLES)
        begin
            handles_used++;
            asked_size[handles_used] = 32'(size);
        end
    endtask

    // Lower valid and hold off until every pending result word has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Mostly spent handles, often the 16 latest (likeliest live); sometimes any number.
    function automatic logic [HID_W-1:0] pick_handle();
        int unsigned lo;
        if (handles_used == 0 || $urandom_range(0, 9) == 0)
            return HID_W'($urandom_range(0, 2**HID_W - 1));
        lo = ($urandom_range(0, 1) == 0 && handles_used > 16) ? handles_used - 15 : 1;
        return HID_W'($urandom_range(lo, handles_used));
    endfunction

    task automatic send_random();
        int unsigned        pick;
        int unsigned        sel;
        logic [REQ_W-1:0]   kind;
        logic [SIZE_W-1:0]  size;
        logic [HID_W-1:0]   hid;
        logic [RANK_W-1:0]  rank;
        pick = $urandom_range(0, 99);
        size = SIZE_W'($urandom_range(0, 2**SIZE_W - 1));
        hid  = HID_W'($urandom_range(0, 2**HID_W - 1));
        rank = RANK_W'($urandom_range(0, 2**RANK_W - 1));
        if (pick < 46)
        begin
            kind = REQ_ALLOC;
            sel = $urandom_range(0, 19);
            if (sel == 0)
                size = '0;
            else if (sel == 1)
                size = SIZE_W'($urandom_range(64, UNITS));
            else
                size = SIZE_W'($urandom_range(1, 16));
        end
        else if (pick < 70)
        begin
            kind = REQ_FREE;
            hid = pick_handle();
        end
        else if (pick < 95)
        begin
            kind = REQ_QUERY;
            hid = pick_handle();
            // Most queries ask for a rank the handle should hold.
            if (asked_size[hid] != 0 && $urandom_range(0, 7) != 0)
                rank = RANK_W'($urandom_range(0, (asked_size[hid] > UNITS) ? UNITS - 1
                                                                   : asked_size[hid] - 1));
        end
        else
        begin
            kind = REQ_UNUSED;
        end
        send_request(kind, size, hid, rank);
    endtask

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bad handles and the unused request kind on an empty pool.
        send_request(REQ_QUERY, 0, 0, 0);
        send_request(REQ_FREE, 0, 0, 0);
        send_request(REQ_UNUSED, 2047, 255, 1023);
        // A zero-size allocation is live but owns nothing.
        send_request(REQ_ALLOC, 0, 0, 0);
        send_request(REQ_QUERY, 0, 1, 0);
        send_request(REQ_ALLOC, 3, 0, 0);
        send_request(REQ_ALLOC, 5, 0, 0);
        send_request(REQ_FREE, 0, 2, 0);
        // This one fills the hole left by handle 2 and then continues after handle 3.
        send_request(REQ_ALLOC, 4, 0, 0);
        send_request(REQ_QUERY, 0, 4, 3);
        send_request(REQ_QUERY, 0, 4, 4);
        send_request(REQ_QUERY, 0, 3, 0);
        send_request(REQ_FREE, 0, 2, 0);
        send_request(REQ_FREE, 0, 1, 0);
        send_request(REQ_QUERY, 0, 200, 0);
        // Oversized request: the handle number is used up and never becomes live.
        send_request(REQ_ALLOC, 2047, 0, 0);
        send_request(REQ_QUERY, 0, 5, 0);
        send_request(REQ_FREE, 0, 5, 0);
        send_request(REQ_FREE, 0, 3, 0);
        send_request(REQ_FREE, 0, 4, 0);
        // Whole pool in one handle, then nothing is left for the next one.
        send_request(REQ_ALLOC, SIZE_W'(UNITS), 0, 0);
        send_request(REQ_QUERY, 0, 6, RANK_W'(UNITS - 1));
        send_request(REQ_ALLOC, 1, 0, 0);
        send_request(REQ_FREE, 0, 6, 0);
        send_request(REQ_FREE, 0, 255, 1023);
        wait_drained();

        for (phase = 0; phase < PHASES; phase++)
        begin
            send_idle_pct   = phase_idle[phase];
            ready_stall_pct = phase_stall[phase];
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                send_random();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/lfua_pkg.sv
hdl/lfua_dp.sv
hdl/lfua_ctrl.sv
hdl/lowest_first_unit_allocator.sv
tb/allocator_check.sv
tb/tb.sv
